/* design/rwc_pkg.sv */
package rwc_pkg;

	localparam int RWC_WAYS          = 8;
	localparam int RWC_WINDOW_BLOCKS = 32;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FILL   = 1'b1;

	localparam logic [1:0] KIND_COPY  = 2'd0;
	localparam logic [1:0] KIND_FETCH = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;
	localparam logic [1:0] KIND_ORDER = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [30:0] block_addr;
		logic [15:0] blocks_left;
		logic [5:0]  fill_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  way_index;
		logic [4:0]  block_offset;
		logic [5:0]  take_count;
		logic [30:0] fetch_addr;
	} rsp_t;

	typedef struct packed {
		logic latch_req;
		logic make_order;
		logic scan_start;
		logic rd_en;
		logic resolve;
		logic fill;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic order_err;
		logic is_fill;
		logic scan_last;
	} sts_t;

endpackage

/* design/rwc_ctrl.sv */
module rwc_ctrl import rwc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_EVAL    = 3'd3;
	localparam logic [2:0] ST_RESOLVE = 3'd4;
	localparam logic [2:0] ST_FILL    = 3'd5;
	localparam logic [2:0] ST_RESP    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.order_err) begin
					cmd.make_order = 1'b1;
					state_d        = ST_RESP;
				end else if (sts.is_fill) begin
					state_d = ST_FILL;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d     = ST_RESP;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/rwc_datapath.sv */
module rwc_datapath import rwc_pkg::*; #(
	parameter int WAYS          = RWC_WAYS,
	parameter int WINDOW_BLOCKS = RWC_WINDOW_BLOCKS
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	req_t              req_q;
	rsp_t              res_q;
	rsp_t              res_d;
	rsp_t              rsp_q;

	logic [WAYS-1:0]   valid_q;
	logic [WAYS-1:0]   stamp_set_q;
	logic [63:0]       use_clock_q;
	logic              fill_pending_q;
	logic [WAY_W-1:0]  pending_way_q;
	logic [30:0]       pending_addr_q;
	logic [15:0]       pending_left_q;

	logic [30:0]       base_mem [WAYS];
	logic [5:0]        count_mem [WAYS];
	logic [63:0]       stamp_mem [WAYS];

	logic [WAY_W-1:0]  scan_idx_q;
	logic              pipe_s1;
	logic [WAY_W-1:0]  idx_s1;
	logic [30:0]       base_s1;
	logic [5:0]        count_s1;
	logic [63:0]       stamp_s1;
	logic              set_s1;
	logic              way_valid_s1;

	logic              hit_q;
	logic [WAY_W-1:0]  hit_way_q;
	logic [5:0]        hit_off_q;
	logic [5:0]        hit_cnt_q;
	logic [63:0]       min_q;
	logic [WAY_W-1:0]  victim_q;

	logic [31:0]       diff;
	logic              covers;
	logic [63:0]       stamp_eff;
	logic              lower;
	logic [63:0]       use_next;
	logic [5:0]        hit_avail;
	logic [5:0]        hit_take;
	logic              fill_zero;
	logic              fill_big;
	logic [5:0]        fill_sat;
	logic [5:0]        fill_take;
	logic              stamp_we;
	logic [WAY_W-1:0]  stamp_wa;
	logic              base_we;

	assign sts.order_err = (req_q.operation == OP_LOOKUP)
		? (fill_pending_q || (req_q.blocks_left == 16'd0))
		: !fill_pending_q;
	assign sts.is_fill   = (req_q.operation == OP_FILL);
	assign sts.scan_last = (scan_idx_q == WAY_W'(WAYS - 1));

	assign rsp = rsp_q;

	assign diff      = {1'b0, req_q.block_addr} - {1'b0, base_s1};
	assign covers    = way_valid_s1 && !diff[31] && (diff[30:6] == '0)
		&& (diff[5:0] < count_s1);
	assign stamp_eff = set_s1 ? stamp_s1 : 64'd0;
	assign lower     = (idx_s1 == '0) || (stamp_eff < min_q);

	assign use_next  = use_clock_q + 64'd1;
	assign hit_avail = hit_cnt_q - hit_off_q;
	assign hit_take  = (req_q.blocks_left < {10'b0, hit_avail})
		? req_q.blocks_left[5:0] : hit_avail;
	assign fill_zero = (req_q.fill_count == 6'd0);
	assign fill_big  = ({1'b0, req_q.fill_count} > 7'(WINDOW_BLOCKS));
	assign fill_sat  = fill_big ? 6'(WINDOW_BLOCKS) : req_q.fill_count;
	assign fill_take = (pending_left_q < {10'b0, fill_sat})
		? pending_left_q[5:0] : fill_sat;

	assign base_we  = cmd.fill && !fill_zero;
	assign stamp_we = (cmd.resolve && hit_q) || base_we;
	assign stamp_wa = cmd.resolve ? hit_way_q : pending_way_q;

	always_comb begin
		res_d = '0;
		if (cmd.make_order) begin
			res_d.kind = KIND_ORDER;
		end else if (cmd.resolve) begin
			if (hit_q) begin
				res_d.kind         = KIND_COPY;
				res_d.way_index    = 3'(hit_way_q);
				res_d.block_offset = hit_off_q[4:0];
				res_d.take_count   = hit_take;
			end else begin
				res_d.kind       = KIND_FETCH;
				res_d.way_index  = 3'(victim_q);
				res_d.fetch_addr = req_q.block_addr;
			end
		end else if (cmd.fill) begin
			res_d.way_index = 3'(pending_way_q);
			if (fill_zero) begin
				res_d.kind = KIND_ABORT;
			end else begin
				res_d.kind       = KIND_COPY;
				res_d.take_count = fill_take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (base_we) begin
			base_mem[pending_way_q]  <= pending_addr_q;
			count_mem[pending_way_q] <= fill_sat;
		end
		if (stamp_we) begin
			stamp_mem[stamp_wa] <= use_next;
		end
		if (cmd.rd_en) begin
			base_s1      <= base_mem[scan_idx_q];
			count_s1     <= count_mem[scan_idx_q];
			stamp_s1     <= stamp_mem[scan_idx_q];
			set_s1       <= stamp_set_q[scan_idx_q];
			way_valid_s1 <= valid_q[scan_idx_q];
			idx_s1       <= scan_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
		if (pipe_s1) begin
			if (!hit_q && covers) begin
				hit_way_q <= idx_s1;
				hit_off_q <= diff[5:0];
				hit_cnt_q <= count_s1;
			end
			if (lower) begin
				min_q    <= stamp_eff;
				victim_q <= idx_s1;
			end
		end
		if (cmd.make_order || cmd.resolve || cmd.fill) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			stamp_set_q    <= '0;
			use_clock_q    <= '0;
			fill_pending_q <= 1'b0;
			pending_way_q  <= '0;
			pending_addr_q <= '0;
			pending_left_q <= '0;
			scan_idx_q     <= '0;
			pipe_s1        <= 1'b0;
			hit_q          <= 1'b0;
		end else begin
			pipe_s1 <= cmd.rd_en;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (pipe_s1 && covers) begin
					hit_q <= 1'b1;
				end
			end
			if (stamp_we) begin
				use_clock_q           <= use_next;
				stamp_set_q[stamp_wa] <= 1'b1;
			end
			if (cmd.resolve && !hit_q) begin
				fill_pending_q <= 1'b1;
				pending_way_q  <= victim_q;
				pending_addr_q <= req_q.block_addr;
				pending_left_q <= req_q.blocks_left;
			end
			if (cmd.fill) begin
				fill_pending_q         <= 1'b0;
				valid_q[pending_way_q] <= !fill_zero;
			end
		end
	end

endmodule

/* design/readahead_window_cache.sv */
// Read-ahead window cache controller.
// The req channel carries lookups (block address, blocks wanted) and fill
// reports (blocks delivered by a window fetch). The rsp channel returns one
// result per request: copy, fetch request, fetch abort or out-of-order error.
// A lookup scans all ways through the tag and stamp memories, one way per
// cycle, checking window coverage and tracking the least-recently-used way.
// A lookup passes through the decode, scan, evaluate, resolve and response
// states; a fill report goes through decode, fill and response, and an
// out-of-order request goes from decode straight to response.
// The result sits in an output register; a stalled receiver holds rsp and
// the controller waits with the next result until that register frees, while
// req_ready stays low from acceptance until the result is handed over.
// Reset clears all way valid bits, stamp-set flags, the use clock and
// any pending fill; bases, counts and stamps are not cleared, nor need be.
module readahead_window_cache import rwc_pkg::*; #(
	parameter int WAYS          = RWC_WAYS,
	parameter int WINDOW_BLOCKS = RWC_WINDOW_BLOCKS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	rwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rwc_datapath #(
		.WAYS          (WAYS),
		.WINDOW_BLOCKS (WINDOW_BLOCKS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import rwc_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	readahead_window_cache u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic        way_live [RWC_WAYS];
	logic [30:0] win_base [RWC_WAYS];
	logic [5:0]  win_len  [RWC_WAYS];
	logic [63:0] win_stamp[RWC_WAYS];
	logic [63:0] use_tick;
	logic        await_fill;
	logic [2:0]  await_way;
	logic [30:0] await_addr;
	logic [15:0] await_left;

	rsp_t window_results_due[$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int mismatches    = 0;
	int copies        = 0;
	int fetches       = 0;
	int aborts        = 0;
	int order_errs    = 0;
	int idle_cycles   = 0;

	function automatic rsp_t predict_window_result(input req_t r);
		rsp_t        o;
		int          hit;
		logic [2:0]  victim;
		logic [31:0] span_end;
		logic [31:0] off;
		logic [31:0] avail;
		logic [5:0]  cnt;
		o      = '0;
		hit    = -1;
		victim = 3'd0;
		if (r.operation == OP_LOOKUP) begin
			if (await_fill || r.blocks_left == 16'd0) begin
				o.kind = KIND_ORDER;
				return o;
			end
			for (int i = 0; i < RWC_WAYS; i++) begin
				span_end = {1'b0, win_base[i]} + {26'd0, win_len[i]};
				if (hit < 0 && way_live[i] && r.block_addr >= win_base[i]
					&& {1'b0, r.block_addr} < span_end)
					hit = i;
			end
			if (hit >= 0) begin
				off   = {1'b0, r.block_addr} - {1'b0, win_base[hit]};
				avail = {26'd0, win_len[hit]} - off;
				use_tick++;
				win_stamp[hit] = use_tick;
				o.kind         = KIND_COPY;
				o.way_index    = 3'(hit);
				o.block_offset = off[4:0];
				o.take_count   = ({16'd0, r.blocks_left} < avail) ?
					r.blocks_left[5:0] : avail[5:0];
				return o;
			end
			for (int i = 1; i < RWC_WAYS; i++)
				if (win_stamp[i] < win_stamp[victim])
					victim = 3'(i);
			await_fill   = 1'b1;
			await_way    = victim;
			await_addr   = r.block_addr;
			await_left   = r.blocks_left;
			o.kind       = KIND_FETCH;
			o.way_index  = victim;
			o.fetch_addr = r.block_addr;
			return o;
		end
		if (!await_fill) begin
			o.kind = KIND_ORDER;
			return o;
		end
		await_fill  = 1'b0;
		o.way_index = await_way;
		if (r.fill_count == 6'd0) begin
			way_live[await_way] = 1'b0;
			o.kind              = KIND_ABORT;
			return o;
		end
		cnt = (r.fill_count > 6'(RWC_WINDOW_BLOCKS)) ? 6'(RWC_WINDOW_BLOCKS) : r.fill_count;
		way_live[await_way] = 1'b1;
		win_base[await_way] = await_addr;
		win_len[await_way]  = cnt;
		use_tick++;
		win_stamp[await_way] = use_tick;
		o.kind       = KIND_COPY;
		o.take_count = (await_left < {10'd0, cnt}) ? await_left[5:0] : cnt;
		return o;
	endfunction

	function automatic req_t lookup_req(input logic [30:0] addr, input logic [15:0] left);
		req_t r;
		r.operation   = OP_LOOKUP;
		r.block_addr  = addr;
		r.blocks_left = left;
		r.fill_count  = 6'($urandom_range(0, 63));
		return r;
	endfunction

	function automatic req_t fill_req(input logic [5:0] cnt);
		req_t r;
		r.operation   = OP_FILL;
		r.block_addr  = 31'($urandom);
		r.blocks_left = 16'($urandom);
		r.fill_count  = cnt;
		return r;
	endfunction

	function automatic req_t random_request();
		int unsigned pick;
		int unsigned w;
		logic [31:0] a;
		logic [15:0] left;
		logic [5:0]  cnt;
		pick = $urandom_range(0, 99);
		if (await_fill) begin
			if (pick < 8)
				return lookup_req(31'($urandom), 16'($urandom_range(1, 65535)));
			pick = $urandom_range(0, 99);
			if (pick < 10)
				cnt = 6'd0;
			else if (pick < 20)
				cnt = 6'($urandom_range(33, 63));
			else
				cnt = 6'($urandom_range(1, 32));
			return fill_req(cnt);
		end
		if (pick < 4)
			return fill_req(6'($urandom_range(0, 63)));
		pick = $urandom_range(0, 99);
		if (pick < 3)
			left = 16'd0;
		else if (pick < 65)
			left = 16'($urandom_range(1, 40));
		else if (pick < 90)
			left = 16'($urandom_range(1, 65535));
		else
			left = 16'hFFFF;
		pick = $urandom_range(0, 99);
		w    = $urandom_range(0, RWC_WAYS - 1);
		if (pick < 60 && way_live[w])
			a = {1'b0, win_base[w]} + $urandom_range(0, win_len[w] + 1);
		else if (pick < 85)
			a = $urandom_range(0, 511);
		else if (pick < 93)
			a = 32'h7FFF_FFFF - $urandom_range(0, 63);
		else
			a = $urandom;
		return lookup_req(a[30:0], left);
	endfunction

	task automatic send_request(input req_t item);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (!req_ready);
		window_results_due.push_back(predict_window_result(item));
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (window_results_due.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (window_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb_top: unexpected result kind=%0d way=%0d off=%0d take=%0d addr=%h",
						rsp.kind, rsp.way_index, rsp.block_offset, rsp.take_count,
						rsp.fetch_addr);
			end else begin
				want = window_results_due.pop_front();
				case (want.kind)
					KIND_COPY:  copies++;
					KIND_FETCH: fetches++;
					KIND_ABORT: aborts++;
					default:    order_errs++;
				endcase
				if (rsp.kind !== want.kind || rsp.way_index !== want.way_index
					|| rsp.block_offset !== want.block_offset
					|| rsp.take_count !== want.take_count
					|| rsp.fetch_addr !== want.fetch_addr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb_top: result %0d expected kind=%0d way=%0d off=%0d take=%0d addr=%h, got kind=%0d way=%0d off=%0d take=%0d addr=%h",
							results_seen, want.kind, want.way_index, want.block_offset,
							want.take_count, want.fetch_addr, rsp.kind, rsp.way_index,
							rsp.block_offset, rsp.take_count, rsp.fetch_addr);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: no request or result moved for %0d cycles", IDLE_LIMIT);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	task automatic test_order_errors();
		send_request(fill_req(6'd5));
		send_request(lookup_req(31'd100, 16'd0));
	endtask

	task automatic test_miss_fill_hit();
		send_request(lookup_req(31'd0, 16'hFFFF));
		send_request(lookup_req(31'd7, 16'd1));
		send_request(fill_req(6'd63));
		send_request(lookup_req(31'd31, 16'hFFFF));
		send_request(lookup_req(31'd5, 16'd3));
		send_request(lookup_req(31'd32, 16'd4));
		send_request(fill_req(6'd1));
		send_request(lookup_req(31'h7FFF_FFFF, 16'd16));
		send_request(fill_req(6'd32));
		send_request(lookup_req(31'h7FFF_FFFF, 16'd100));
		send_request(lookup_req(31'h7FFF_FFE0, 16'd2));
		send_request(fill_req(6'd0));
		send_request(lookup_req(31'h7FFF_FFE0, 16'd2));
		send_request(fill_req(6'd33));
		send_request(lookup_req(31'h7FFF_FFFF, 16'hFFFF));
		send_request(lookup_req(31'h7FFF_FFF0, 16'd40));
		send_request(fill_req(6'd20));
		wait_drained();
	endtask

	task automatic test_random_traffic(input int count, input int send_pct, input int rx_pct);
		send_idle_pct = send_pct;
		stall_pct     = rx_pct;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_drained();
			send_request(random_request());
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < RWC_WAYS; i++) begin
			way_live[i]  = 1'b0;
			win_base[i]  = '0;
			win_len[i]   = '0;
			win_stamp[i] = '0;
		end
		use_tick   = '0;
		await_fill = 1'b0;
		await_way  = '0;
		await_addr = '0;
		await_left = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_order_errors();
		test_miss_fill_hit();
		test_random_traffic(220, 0, 0);
		test_random_traffic(220, 66, 0);
		test_random_traffic(220, 0, 66);
		test_random_traffic(220, 21, 21);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("tb_top: %0d requests, %0d results: %0d copies, %0d fetches, %0d aborts, %0d out of order",
			items_sent, results_seen, copies, fetches, aborts, order_errs);
		$display("tb_top: idle and stall mixes covered, %0d mismatches, %0d results missing",
			mismatches, window_results_due.size());
		if (mismatches == 0 && window_results_due.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
design/rwc_pkg.sv
design/rwc_ctrl.sv
design/rwc_datapath.sv
design/readahead_window_cache.sv
tb/tb_top.sv
